FILE: rtl/vnorm_pkg.sv
package vnorm_pkg;

	localparam int CompW    = 16;
	localparam int FracOutW = 14;
	localparam int SumW     = 32;
	localparam int RootW    = 16;
	localparam int QuotW    = FracOutW + 1;
	localparam int SqrtStages = RootW;
	localparam int DivStages  = QuotW;
	localparam int PipeDepth  = 2 + SqrtStages + DivStages;

	typedef struct packed {
		logic [CompW-1:0] mag;
		logic             neg;
	} vnorm_lane_t;

endpackage

FILE: rtl/vnorm_if.sv
interface vnorm_in_if
	import vnorm_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic signed [CompW-1:0] in_x;
	logic signed [CompW-1:0] in_y;
	logic signed [CompW-1:0] in_z;

	modport source (output valid, in_x, in_y, in_z, input ready);
	modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface

interface vnorm_out_if
	import vnorm_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic signed [CompW-1:0] unit_x;
	logic signed [CompW-1:0] unit_y;
	logic signed [CompW-1:0] unit_z;
	logic        [RootW-1:0] magnitude;
	logic                    is_zero;

	modport source (output valid, unit_x, unit_y, unit_z, magnitude, is_zero, input ready);
	modport sink (input valid, unit_x, unit_y, unit_z, magnitude, is_zero, output ready);
endinterface

FILE: rtl/vnorm_sqrt.sv
module vnorm_sqrt
	import vnorm_pkg::*;
	(
	input  logic             clk,
	input  logic             en,
	input  logic [SumW-1:0]  n,
	output logic [RootW-1:0] root
);

	logic [RootW+1:0] rem_s  [SqrtStages];
	logic [RootW-1:0] root_s [SqrtStages];
	logic [SumW-1:0]  n_s    [SqrtStages];

	for (genvar i = 0; i < SqrtStages; i++) begin : g_stage
		logic [RootW+1:0] rem_p;
		logic [RootW-1:0] root_p;
		logic [SumW-1:0]  n_p;
		logic [RootW+3:0] cur;
		logic [RootW+3:0] trial;
		logic             ge;

		if (i == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign n_p    = n;
		end else begin : g_next
			assign rem_p  = rem_s[i-1];
			assign root_p = root_s[i-1];
			assign n_p    = n_s[i-1];
		end

		always_comb begin
			cur   = {rem_p, n_p[SumW-1 -: 2]};
			trial = {2'b00, root_p, 2'b01};
			ge    = (cur >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? (RootW+2)'(cur - trial) : cur[RootW+1:0];
				root_s[i] <= {root_p[RootW-2:0], ge};
				n_s[i]    <= {n_p[SumW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[SqrtStages-1];

endmodule

FILE: rtl/vnorm_div.sv
module vnorm_div
	import vnorm_pkg::*;
	(
	input  logic                    clk,
	input  logic                    en,
	input  vnorm_lane_t             lane,
	input  logic [RootW-1:0]        len,
	output logic signed [CompW-1:0] unit
);

	logic [RootW:0]   rem_s [DivStages];
	logic [QuotW-1:0] quo_s [DivStages];
	logic [RootW-1:0] len_s [DivStages];
	logic             neg_s [DivStages];

	for (genvar i = 0; i < DivStages; i++) begin : g_stage
		logic [RootW:0]   rem_p;
		logic [QuotW-1:0] quo_p;
		logic [RootW-1:0] len_p;
		logic             neg_p;
		logic             ge;
		logic [RootW:0]   diff;

		if (i == 0) begin : g_first
			assign rem_p = {1'b0, lane.mag};
			assign quo_p = '0;
			assign len_p = len;
			assign neg_p = lane.neg;
		end else begin : g_next
			assign rem_p = rem_s[i-1];
			assign quo_p = quo_s[i-1];
			assign len_p = len_s[i-1];
			assign neg_p = neg_s[i-1];
		end

		always_comb begin
			ge   = (rem_p >= {1'b0, len_p});
			diff = ge ? rem_p - {1'b0, len_p} : rem_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= {diff[RootW-1:0], 1'b0};
				quo_s[i] <= {quo_p[QuotW-2:0], ge};
				len_s[i] <= len_p;
				neg_s[i] <= neg_p;
			end
		end
	end

	logic [CompW-1:0] q_ext;
	assign q_ext = {{(CompW-QuotW){1'b0}}, quo_s[DivStages-1]};
	assign unit  = neg_s[DivStages-1] ? signed'(-q_ext) : signed'(q_ext);

endmodule

FILE: rtl/vector3_normalize_unit.sv
// Fully pipelined: one item accepted per cycle while the output is not stalled.
// Items pass the squaring and sum registers, the 16-stage square root, the 15-stage
// divider lanes and the output register. A stall at the output freezes the whole
// pipeline; an item still enters while the output register is empty or being taken.
// arst_n clears all valid bits; data registers are not reset.
module vector3_normalize_unit
	import vnorm_pkg::*;
	(
	input  logic   clk,
	input  logic   arst_n,
	vnorm_in_if.sink    vec,
	vnorm_out_if.source res
);

	logic en;
	logic out_valid_q;
	logic [PipeDepth-1:0] vld_s;

	assign en        = !out_valid_q || res.ready;
	assign vec.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[PipeDepth-2:0], vec.valid};
			out_valid_q <= vld_s[PipeDepth-1];
		end
	end

	vnorm_lane_t       lane_s1 [3];
	logic [2*CompW-1:0] sq_s1  [3];
	vnorm_lane_t       lane_s2 [3];
	logic [SumW-1:0]   sum_s2;
	logic signed [CompW-1:0] comp [3];

	assign comp[0] = vec.in_x;
	assign comp[1] = vec.in_y;
	assign comp[2] = vec.in_z;

	for (genvar k = 0; k < 3; k++) begin : g_sq
		logic [CompW-1:0] mag;
		assign mag = comp[k][CompW-1] ? CompW'(-comp[k]) : CompW'(comp[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				lane_s1[k] <= '{mag: mag, neg: comp[k][CompW-1]};
				sq_s1[k]   <= mag * mag;
				lane_s2[k] <= lane_s1[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= SumW'(sq_s1[0]) + SumW'(sq_s1[1]) + SumW'(sq_s1[2]);
		end
	end

	logic [RootW-1:0] root;
	vnorm_sqrt u_sqrt (.clk(clk), .en(en), .n(sum_s2), .root(root));

	vnorm_lane_t lane_d [SqrtStages][3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < SqrtStages; s++) begin
				for (int k = 0; k < 3; k++) begin
					lane_d[s][k] <= (s == 0) ? lane_s2[k] : lane_d[s-1][k];
				end
			end
		end
	end

	logic signed [CompW-1:0] unit [3];
	for (genvar k = 0; k < 3; k++) begin : g_lane
		vnorm_div u_div (
			.clk(clk), .en(en), .lane(lane_d[SqrtStages-1][k]), .len(root), .unit(unit[k])
		);
	end

	logic [RootW-1:0] mag_d [DivStages];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < DivStages; s++) begin
				mag_d[s] <= (s == 0) ? root : mag_d[s-1];
			end
		end
	end

	logic zero;
	logic signed [CompW-1:0] ux_q, uy_q, uz_q;
	logic [RootW-1:0] mag_q;
	logic zero_q;

	assign zero = (mag_d[DivStages-1] == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			ux_q   <= zero ? '0 : unit[0];
			uy_q   <= zero ? '0 : unit[1];
			uz_q   <= zero ? '0 : unit[2];
			mag_q  <= mag_d[DivStages-1];
			zero_q <= zero;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.unit_x    = ux_q;
	assign res.unit_y    = uy_q;
	assign res.unit_z    = uz_q;
	assign res.magnitude = mag_q;
	assign res.is_zero   = zero_q;

	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.is_zero |-> res.magnitude == '0 && res.unit_x == '0
			&& res.unit_y == '0 && res.unit_z == '0)
		else $error("zero-length item carries nonzero fields");

	a_flag_match: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.is_zero |-> res.magnitude != '0)
		else $error("is_zero disagrees with magnitude");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.unit_x <= 16'sd16384 && res.unit_x >= -16'sd16384
			&& res.unit_y <= 16'sd16384 && res.unit_y >= -16'sd16384
			&& res.unit_z <= 16'sd16384 && res.unit_z >= -16'sd16384)
		else $error("unit component out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.magnitude))
		else $error("stalled result changed");

endmodule
